FILE: sv/luf_pkg.sv
// Shared types and constants for the longest unique run finder.
package luf_pkg;

  localparam int POS_BITS_DEF = 16;
  localparam int SYM_W        = 8;
  localparam int SYMS         = 256;
  localparam int LEN_W        = 17;
  localparam int POS_W        = 16;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last_symbol;
  } in_word_t;

  typedef struct packed {
    logic [LEN_W-1:0] best_length;
    logic [POS_W-1:0] best_start;
    logic [POS_W-1:0] best_end;
    logic             final_result;
    logic             overflow;
  } out_word_t;

  typedef struct packed {
    logic wr_en;
    logic clr;
  } tbl_ctrl_t;

endpackage

FILE: sv/luf_seen_table.sv
// Last-seen position table: memory with registered read, valid bits and write forwarding.
module luf_seen_table import luf_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [SYM_W-1:0]    rd_sym_i,
  input  tbl_ctrl_t           ctrl_i,
  input  logic [SYM_W-1:0]    wr_sym_i,
  input  logic [POS_BITS-1:0] wr_pos_i,
  output logic                seen_o,
  output logic [POS_BITS-1:0] pos_o
);

  logic [POS_BITS-1:0] mem [SYMS];
  logic [POS_BITS-1:0] rdata_q;
  logic [SYM_W-1:0]    rd_sym_q;
  logic [SYMS-1:0]     valid_q;
  logic                fw_vld_q;
  logic [SYM_W-1:0]    fw_sym_q;
  logic [POS_BITS-1:0] fw_pos_q;

  // A read in the same cycle as a write returns the old contents.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[wr_sym_i] <= wr_pos_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_sym_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_sym_q <= '0;
      valid_q  <= '0;
      fw_vld_q <= 1'b0;
      fw_sym_q <= '0;
      fw_pos_q <= '0;
    end else begin
      if (rd_en_i) begin
        rd_sym_q <= rd_sym_i;
      end
      if (ctrl_i.clr) begin
        valid_q <= '0;
      end else if (ctrl_i.wr_en) begin
        valid_q[wr_sym_i] <= 1'b1;
      end
      if (ctrl_i.wr_en) begin
        fw_vld_q <= 1'b1;
        fw_sym_q <= wr_sym_i;
        fw_pos_q <= wr_pos_i;
      end
    end
  end

  // The newest write covers the case where it landed on the same edge as the read.
  assign seen_o = valid_q[rd_sym_q];
  assign pos_o  = (fw_vld_q && (fw_sym_q == rd_sym_q)) ? fw_pos_q : rdata_q;

endmodule

FILE: sv/luf_run_core.sv
// Window, position and best-run state with the per-word update logic.
module luf_run_core import luf_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  in_word_t            word_i,
  input  logic                seen_i,
  input  logic [POS_BITS-1:0] seen_pos_i,
  output tbl_ctrl_t           ctrl_o,
  output logic [POS_BITS-1:0] wr_pos_o,
  output out_word_t           result_o
);

  localparam int WIDE_L = (POS_BITS + 1 > LEN_W) ? POS_BITS + 1 : LEN_W;
  localparam int WIDE_P = (POS_BITS > POS_W) ? POS_BITS : POS_W;

  logic [POS_BITS:0]   pos_q, pos_d;
  logic [POS_BITS-1:0] left_q, left_d;
  logic [POS_BITS:0]   best_len_q, best_len_d;
  logic [POS_BITS-1:0] best_start_q, best_start_d;
  logic [POS_BITS-1:0] best_end_q, best_end_d;

  logic                ovf;
  logic [POS_BITS-1:0] p;
  logic [POS_BITS:0]   cand;
  logic [POS_BITS-1:0] left_new;
  logic [POS_BITS:0]   run;
  logic [POS_BITS:0]   bl_new;
  logic [POS_BITS-1:0] bs_new, be_new;
  logic [WIDE_L-1:0]   len_ext;
  logic [WIDE_P-1:0]   start_ext, end_ext;

  always_comb begin
    ovf      = pos_q[POS_BITS];
    p        = pos_q[POS_BITS-1:0];
    cand     = {1'b0, seen_pos_i} + {{POS_BITS{1'b0}}, 1'b1};
    left_new = (seen_i && (cand > {1'b0, left_q})) ? cand[POS_BITS-1:0] : left_q;
    run      = {1'b0, p} - {1'b0, left_new} + {{POS_BITS{1'b0}}, 1'b1};
    bl_new   = best_len_q;
    bs_new   = best_start_q;
    be_new   = best_end_q;
    if (!ovf && (run > best_len_q)) begin
      bl_new = run;
      bs_new = left_new;
      be_new = p;
    end

    if (word_i.last_symbol) begin
      pos_d        = '0;
      left_d       = '0;
      best_len_d   = '0;
      best_start_d = '0;
      best_end_d   = '0;
    end else if (ovf) begin
      pos_d        = pos_q;
      left_d       = left_q;
      best_len_d   = best_len_q;
      best_start_d = best_start_q;
      best_end_d   = best_end_q;
    end else begin
      pos_d        = pos_q + {{POS_BITS{1'b0}}, 1'b1};
      left_d       = left_new;
      best_len_d   = bl_new;
      best_start_d = bs_new;
      best_end_d   = be_new;
    end
  end

  always_comb begin
    len_ext   = WIDE_L'(bl_new);
    start_ext = WIDE_P'(bs_new);
    end_ext   = WIDE_P'(be_new);
    result_o.best_length  = len_ext[LEN_W-1:0];
    result_o.best_start   = start_ext[POS_W-1:0];
    result_o.best_end     = end_ext[POS_W-1:0];
    result_o.final_result = word_i.last_symbol;
    result_o.overflow     = ovf;
    ctrl_o.wr_en          = adv_i && !ovf;
    ctrl_o.clr            = adv_i && word_i.last_symbol;
    wr_pos_o              = p;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      left_q       <= '0;
      best_len_q   <= '0;
      best_start_q <= '0;
      best_end_q   <= '0;
    end else if (adv_i) begin
      pos_q        <= pos_d;
      left_q       <= left_d;
      best_len_q   <= best_len_d;
      best_start_q <= best_start_d;
      best_end_q   <= best_end_d;
    end
  end

endmodule

FILE: sv/longest_unique_run_finder.sv
// Top level of the longest unique run finder: input stage, result register and handshakes.
//
//  Channel | Direction | Handshake                  | Word
//  --------+-----------+----------------------------+------------
//  in      | input     | in_valid_i / in_stall_o    | in_word_t
//  out     | output    | out_valid_o / out_stall_i  | out_word_t
//
// Every accepted word yields exactly one result word, via the stage and result registers.
// One word per cycle is sustained while the output is not stalled; the seen table is a single memory
// with one read and one write per cycle, read when a word is accepted.
// Reset clears the valid bits of the table at once, so no clearing pass
// is needed and a word may be accepted on the first cycle after reset.
// A stalled output holds its result; the input stage keeps taking words
// as long as the stage register can drain into the result register.
module longest_unique_run_finder import luf_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);

  // Stage register: the word whose table lookup is in flight.
  logic      s_vld_q, s_vld_d;
  in_word_t  s_word_q;
  // Result register toward the consumer.
  logic      out_vld_q, out_vld_d;
  out_word_t out_word_q;

  logic                accept;
  logic                adv;
  logic                seen;
  logic [POS_BITS-1:0] seen_pos;
  logic [POS_BITS-1:0] wr_pos;
  tbl_ctrl_t           tbl_ctrl;
  out_word_t           result;

  // The stage word moves on whenever the result register is free or is being taken.
  assign adv        = s_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = s_vld_q && !adv;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    s_vld_d = s_vld_q;
    if (accept) begin
      s_vld_d = 1'b1;
    end else if (adv) begin
      s_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s_vld_q   <= s_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_word_q <= in_data_i;
    end
    if (adv) begin
      out_word_q <= result;
    end
  end

  // The table read is launched with the accept so its data lines up with the stage word.
  luf_seen_table #(
    .POS_BITS(POS_BITS)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (accept),
    .rd_sym_i(in_data_i.symbol),
    .ctrl_i  (tbl_ctrl),
    .wr_sym_i(s_word_q.symbol),
    .wr_pos_i(wr_pos),
    .seen_o  (seen),
    .pos_o   (seen_pos)
  );

  luf_run_core #(
    .POS_BITS(POS_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .word_i    (s_word_q),
    .seen_i    (seen),
    .seen_pos_i(seen_pos),
    .ctrl_o    (tbl_ctrl),
    .wr_pos_o  (wr_pos),
    .result_o  (result)
  );

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_word_q;

endmodule

FILE: sv/luf_checker.sv
// Port-level assertions for the longest unique run finder and their bind.
module luf_checker import luf_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_word_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_data_o
);

  localparam bit NARROW = (POS_BITS <= POS_W);

  logic [LEN_W-1:0] span;
  assign span = {1'b0, out_data_o.best_end} - {1'b0, out_data_o.best_start} + LEN_W'(1);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled input word changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result word changed");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && NARROW |-> out_data_o.best_length != '0)
    else $error("result word reports an empty best run");

  a_len_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && NARROW |-> span == out_data_o.best_length)
    else $error("best length does not match start and end");

  // The handshake flops are cleared by the asynchronous reset.
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && !in_stall_o)
    else $error("handshake active during reset");

endmodule

bind longest_unique_run_finder luf_checker #(
  .POS_BITS(POS_BITS)
) u_luf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);
